// ===== rtl/gyro_quaternion_rk4_increment_unit_assert.svh =====
// assertion macros shared by the gyro quaternion increment rtl
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef GYRO_QUATERNION_RK4_INCREMENT_UNIT_ASSERT_SVH
`define GYRO_QUATERNION_RK4_INCREMENT_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define GQRK4_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define GQRK4_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define GQRK4_ASSERT_NOW(lbl, ck, rn, ante, cons, msg)
`define GQRK4_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg)
`endif
`endif

// ===== rtl/gqrk4_pkg.sv =====
// shared types and saturating helpers for the quaternion increment pipeline
// no dependencies
package gqrk4_pkg;

  // signed Q17.30 intermediate, saturates to +-(2^47 - 1)
  typedef logic signed [47:0] qv_t;

  localparam logic signed [48:0] SAT_HI = 49'sh0_7FFF_FFFF_FFFF;
  localparam logic signed [48:0] SAT_LO = 49'sh1_8000_0000_0001;
  localparam qv_t Q_ONE = 48'sh0000_4000_0000;

  // clamp a grown sum back into the symmetric range
  function automatic qv_t clamp_q(input logic signed [48:0] v);
    qv_t r;
    if (v > SAT_HI) begin
      r = SAT_HI[47:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[47:0];
    end else begin
      r = v[47:0];
    end
    return r;
  endfunction

  // saturating add
  function automatic qv_t add_sat(input qv_t a, input qv_t b);
    logic signed [48:0] s;
    s = $signed({a[47], a}) + $signed({b[47], b});
    return clamp_q(s);
  endfunction

  // magnitude
  function automatic logic [47:0] mag_q(input qv_t v);
    logic [47:0] m;
    m = v[47] ? 48'(-v) : 48'(v);
    return m;
  endfunction

  // divide by two, round half away from zero
  function automatic qv_t rs1(input qv_t v);
    logic [48:0] r;
    qv_t m;
    r = ({1'b0, mag_q(v)} + 49'd1) >> 1;
    m = r[47:0];
    return v[47] ? -m : m;
  endfunction

endpackage

// ===== rtl/gqrk4_slope.sv =====
// one runge-kutta slope: omega(a) applied to a quaternion, three stages
// depends on gqrk4_pkg
module gqrk4_slope
  import gqrk4_pkg::*;
(
  input  logic clk,
  input  logic en,
  input  qv_t  a_i [3],
  input  qv_t  y_i [4],
  output qv_t  s_o [4]
);

  // term k feeds component k/3; rate and quaternion index per term
  localparam logic [1:0] A_SEL [12] = '{2'd2, 2'd1, 2'd0, 2'd2, 2'd0, 2'd1,
                                        2'd1, 2'd0, 2'd2, 2'd0, 2'd1, 2'd2};
  localparam logic [1:0] Y_SEL [12] = '{2'd1, 2'd2, 2'd3, 2'd0, 2'd2, 2'd3,
                                        2'd0, 2'd1, 2'd3, 2'd0, 2'd1, 2'd2};
  localparam logic [11:0] NEG_TERM = 12'b1110_1000_1010;

  logic [47:0] pp_r   [12][4];
  logic [47:0] pp_nxt [12][4];
  logic        neg_r   [12];
  logic        neg_nxt [12];
  qv_t         prod_r   [12];
  qv_t         prod_nxt [12];
  qv_t         s_r   [4];
  qv_t         s_nxt [4];

  // stage one: 24-bit partial products of the magnitudes
  always_comb begin
    logic [47:0] ma, mb;
    for (int k = 0; k < 12; k++) begin
      ma = mag_q(a_i[A_SEL[k]]);
      mb = mag_q(y_i[Y_SEL[k]]);
      pp_nxt[k][0] = ma[23:0] * mb[23:0];
      pp_nxt[k][1] = ma[23:0] * mb[47:24];
      pp_nxt[k][2] = ma[47:24] * mb[23:0];
      pp_nxt[k][3] = ma[47:24] * mb[47:24];
      neg_nxt[k] = a_i[A_SEL[k]][47] ^ y_i[Y_SEL[k]][47] ^ NEG_TERM[k];
    end
  end

  // stage two: combine, round the q30 product, saturate, sign
  always_comb begin
    logic [95:0] full;
    logic [65:0] rq;
    qv_t         m;
    for (int k = 0; k < 12; k++) begin
      full = ({48'd0, pp_r[k][3]} << 48) + ({48'd0, pp_r[k][1]} << 24)
           + ({48'd0, pp_r[k][2]} << 24) + {48'd0, pp_r[k][0]} + (96'd1 << 29);
      rq = full[95:30];
      if (rq > 66'(SAT_HI[47:0])) begin
        m = SAT_HI[47:0];
      end else begin
        m = rq[47:0];
      end
      prod_nxt[k] = neg_r[k] ? -m : m;
    end
  end

  // stage three: left-to-right saturating sums
  always_comb begin
    for (int o = 0; o < 4; o++) begin
      s_nxt[o] = add_sat(add_sat(prod_r[3*o], prod_r[3*o+1]), prod_r[3*o+2]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pp_r   <= pp_nxt;
      neg_r  <= neg_nxt;
      prod_r <= prod_nxt;
      s_r    <= s_nxt;
    end
  end

  assign s_o = s_r;

endmodule

// ===== rtl/gyro_quaternion_rk4_increment_unit.sv =====
// Gyro quaternion increment by fourth-order Runge-Kutta, fully pipelined.
// One transfer is accepted every clock cycle while the skid register is empty,
// and each result passes through 84 pipeline stages plus the output register.
// Most stages are in the normalization: a 32-stage square root that resolves
// one result bit per stage, followed by a 32-stage divider that forms the rounded
// dividend in its first stage and then resolves one quotient bit per stage for
// all four components at once. The slopes run in three-stage units with split
// 24-bit multipliers. A skid register behind the output register takes one more
// finished result while the output waits; once it is full the whole pipeline
// and the input side freeze on out_tready without loss.
// depends on gqrk4_pkg, gqrk4_slope and the assertion macro header
`include "gyro_quaternion_rk4_increment_unit_assert.svh"
module gyro_quaternion_rk4_increment_unit
  import gqrk4_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // prev_rate_x, prev_rate_y, prev_rate_z, curr_rate_x, curr_rate_y,
  // curr_rate_z (32 bits each), step_time (24 bits)
  input  logic [215:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // quat_x, quat_y, quat_z, quat_w (32 bits each)
  output logic [127:0] out_tdata
);

  localparam int LAT = 84;
  localparam logic [3:0] SH_ENDS = 4'd11;
  localparam logic [3:0] SH_MID  = 4'd12;
  localparam logic [31:0] OUT_ONE = 32'h4000_0000;

  // identity quaternion component
  function automatic qv_t ident(input logic [1:0] i);
    return (i == 2'd3) ? Q_ONE : '0;
  endfunction

  // round-half-away shift of a scaled rate product
  function automatic qv_t rnd_shift(input logic signed [57:0] v, input logic [3:0] n);
    logic [57:0] m, r;
    qv_t         q;
    m = v[57] ? 58'(-v) : 58'(v);
    r = (m + (58'd1 << (n - 4'd1))) >> n;
    q = r[47:0];
    return v[57] ? -q : q;
  endfunction

  logic en, in_xfer;
  logic [LAT-1:0] vld_r;
  logic         out_vld_r, skid_vld_r;
  logic [127:0] out_data_r, skid_data_r;

  assign en = ~skid_vld_r;
  assign in_tready = en;
  assign in_xfer = in_tvalid & en;

  // input fields
  logic signed [31:0] wp [3];
  logic signed [31:0] wc [3];
  logic [23:0] step;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      wp[i] = in_tdata[32*i +: 32];
      wc[i] = in_tdata[96+32*i +: 32];
    end
    step = in_tdata[215:192];
  end

  // stage 1: step times rate
  logic signed [56:0] pp_prev_r [3], pp_prev_nxt [3];
  logic signed [56:0] pp_curr_r [3], pp_curr_nxt [3];
  logic signed [57:0] pp_mid_r  [3], pp_mid_nxt  [3];

  always_comb begin
    logic signed [32:0] wsum;
    for (int i = 0; i < 3; i++) begin
      wsum = $signed({wp[i][31], wp[i]}) + $signed({wc[i][31], wc[i]});
      pp_prev_nxt[i] = $signed({1'b0, step}) * wp[i];
      pp_curr_nxt[i] = $signed({1'b0, step}) * wc[i];
      pp_mid_nxt[i]  = $signed({1'b0, step}) * wsum;
    end
  end

  // stage 2: half-angle vectors and the second stage quaternion
  qv_t ap_nxt [3], am_nxt [3], ac_nxt [3];
  qv_t st2_r [4], st2_nxt [4];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ap_nxt[i] = rnd_shift($signed({pp_prev_r[i][56], pp_prev_r[i]}), SH_ENDS);
      ac_nxt[i] = rnd_shift($signed({pp_curr_r[i][56], pp_curr_r[i]}), SH_ENDS);
      am_nxt[i] = rnd_shift(pp_mid_r[i], SH_MID);
      st2_nxt[i] = rs1(ap_nxt[i]);
    end
    st2_nxt[3] = Q_ONE;
  end

  // delay lines that keep vectors and slopes aligned with the pipeline
  qv_t ap_d [12][3];
  qv_t am_d [5][3];
  qv_t ac_d [9][3];
  qv_t s2_d [8][4];
  qv_t s3_d [4][4];

  qv_t s2w [4], s3w [4], s4w [4];
  qv_t st3_r [4], st3_nxt [4];
  qv_t st4_r [4], st4_nxt [4];

  gqrk4_slope u_k2 (.clk(clk), .en(en), .a_i(am_d[0]), .y_i(st2_r), .s_o(s2w));
  gqrk4_slope u_k3 (.clk(clk), .en(en), .a_i(am_d[4]), .y_i(st3_r), .s_o(s3w));
  gqrk4_slope u_k4 (.clk(clk), .en(en), .a_i(ac_d[8]), .y_i(st4_r), .s_o(s4w));

  // third and fourth stage quaternions
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      st3_nxt[i] = add_sat(ident(2'(i)), rs1(s2w[i]));
      st4_nxt[i] = add_sat(ident(2'(i)), s3w[i]);
    end
  end

  // weighted slope sum, first half
  qv_t u_r [4], u_nxt [4];
  qv_t d3_r [4], d3_nxt [4];
  qv_t s4_r [4];
  qv_t t_r [4], t_nxt [4];

  always_comb begin
    qv_t s1c;
    for (int i = 0; i < 4; i++) begin
      s1c = (i < 3) ? ap_d[11][i] : '0;
      u_nxt[i]  = add_sat(s1c, add_sat(s2_d[7][i], s2_d[7][i]));
      d3_nxt[i] = add_sat(s3_d[3][i], s3_d[3][i]);
      t_nxt[i]  = add_sat(add_sat(u_r[i], d3_r[i]), s4_r[i]);
    end
  end

  // divide by six: halve, then split into 24-bit digits for the divide by three
  logic [45:0] m1_r [4], m1_nxt [4];
  logic [56:0] m2_r [4], m2_nxt [4];
  logic [3:0]  tneg_r;

  always_comb begin
    logic [47:0] tm;
    logic [46:0] u6;
    logic [24:0] ysum;
    for (int i = 0; i < 4; i++) begin
      tm = mag_q(t_r[i]) + 48'd3;
      u6 = tm[47:1];
      ysum = {2'b00, u6[46:24]} + {1'b0, u6[23:0]};
      m1_nxt[i] = u6[46:24] * 23'd5592405;
      m2_nxt[i] = ysum * 32'hAAAA_AAAB;
    end
  end

  // quotient, add identity, take magnitudes
  logic [46:0] mg_r [4], mg_nxt [4];
  logic [3:0]  sgn17_r, sgn17_nxt;

  always_comb begin
    logic [46:0] q;
    logic [47:0] am;
    qv_t qs, acc;
    for (int i = 0; i < 4; i++) begin
      q = 47'(m1_r[i]) + 47'(m2_r[i][56:33]);
      qs = {1'b0, q};
      if (tneg_r[i]) begin
        qs = -qs;
      end
      acc = add_sat(ident(2'(i)), qs);
      am = mag_q(acc);
      mg_nxt[i] = am[46:0];
      sgn17_nxt[i] = acc[47];
    end
  end

  // prescale so the largest magnitude fits 31 bits
  logic [30:0] mgs18_r [4], mgs18_nxt [4];
  logic [3:0]  sgn18_r;

  always_comb begin
    logic [46:0] orv;
    logic [46:0] shv;
    logic [4:0]  sh;
    orv = mg_r[0] | mg_r[1] | mg_r[2] | mg_r[3];
    sh = '0;
    for (int b = 31; b < 47; b++) begin
      if (orv[b]) begin
        sh = 5'(b - 30);
      end
    end
    for (int i = 0; i < 4; i++) begin
      shv = mg_r[i] >> sh;
      mgs18_nxt[i] = shv[30:0];
    end
  end

  // squares and their sum
  logic [61:0] sq_r [4];
  logic [30:0] mgs19_r [4], mgs20_r [4];
  logic [3:0]  sgn19_r, sgn20_r;
  logic [63:0] sum_r, sum_nxt;

  always_comb begin
    sum_nxt = '0;
    for (int i = 0; i < 4; i++) begin
      sum_nxt = sum_nxt + 64'(sq_r[i]);
    end
  end

  // square root, one result bit per stage
  logic [63:0] sv_r [32], sv_nxt [32], sv_in [32];
  logic [63:0] sr_r [32], sr_nxt [32], sr_in [32];
  logic [30:0] mq_r [32][4];
  logic [3:0]  sg_r [32];

  always_comb begin
    logic [63:0] bitv, trial;
    sv_in[0] = sum_r;
    sr_in[0] = '0;
    for (int k = 1; k < 32; k++) begin
      sv_in[k] = sv_r[k-1];
      sr_in[k] = sr_r[k-1];
    end
    for (int k = 0; k < 32; k++) begin
      bitv = 64'd1 << (62 - 2*k);
      trial = sr_in[k] + bitv;
      if (sv_in[k] >= trial) begin
        sv_nxt[k] = sv_in[k] - trial;
        sr_nxt[k] = (sr_in[k] >> 1) + bitv;
      end else begin
        sv_nxt[k] = sv_in[k];
        sr_nxt[k] = sr_in[k] >> 1;
      end
    end
  end

  // restoring divider, one quotient bit per stage
  logic [31:0] dn_r [32];
  logic [31:0] drem_r [32][4], drem_nxt [32][4];
  logic [30:0] dlow_r [32][4], dlow_nxt [32][4];
  logic [30:0] dq_r [32][4], dq_nxt [32][4];
  logic        dz_r [32];
  logic [3:0]  dsg_r [32];

  always_comb begin
    logic [31:0] nrm;
    logic [61:0] nn;
    logic [32:0] rs;
    nrm = sr_r[31][31:0];
    for (int i = 0; i < 4; i++) begin
      nn = {1'b0, mq_r[31][i], 30'd0} + {31'd0, nrm[31:1]};
      drem_nxt[0][i] = {1'b0, nn[61:31]};
      dlow_nxt[0][i] = nn[30:0];
      dq_nxt[0][i] = '0;
    end
    for (int k = 1; k < 32; k++) begin
      for (int i = 0; i < 4; i++) begin
        rs = {drem_r[k-1][i], dlow_r[k-1][i][30]};
        dlow_nxt[k][i] = {dlow_r[k-1][i][29:0], 1'b0};
        if (rs >= {1'b0, dn_r[k-1]}) begin
          rs = rs - {1'b0, dn_r[k-1]};
          dq_nxt[k][i] = {dq_r[k-1][i][29:0], 1'b1};
        end else begin
          dq_nxt[k][i] = {dq_r[k-1][i][29:0], 1'b0};
        end
        drem_nxt[k][i] = rs[31:0];
      end
    end
  end

  // pipeline registers, all advance together
  always_ff @(posedge clk) begin
    if (en) begin
      pp_prev_r <= pp_prev_nxt;
      pp_curr_r <= pp_curr_nxt;
      pp_mid_r  <= pp_mid_nxt;
      st2_r <= st2_nxt;
      ap_d[0] <= ap_nxt;
      am_d[0] <= am_nxt;
      ac_d[0] <= ac_nxt;
      for (int j = 1; j < 12; j++) ap_d[j] <= ap_d[j-1];
      for (int j = 1; j < 5; j++) am_d[j] <= am_d[j-1];
      for (int j = 1; j < 9; j++) ac_d[j] <= ac_d[j-1];
      st3_r <= st3_nxt;
      s2_d[0] <= s2w;
      for (int j = 1; j < 8; j++) s2_d[j] <= s2_d[j-1];
      st4_r <= st4_nxt;
      s3_d[0] <= s3w;
      for (int j = 1; j < 4; j++) s3_d[j] <= s3_d[j-1];
      u_r  <= u_nxt;
      d3_r <= d3_nxt;
      s4_r <= s4w;
      t_r  <= t_nxt;
      m1_r <= m1_nxt;
      m2_r <= m2_nxt;
      for (int i = 0; i < 4; i++) tneg_r[i] <= t_r[i][47];
      mg_r <= mg_nxt;
      sgn17_r <= sgn17_nxt;
      mgs18_r <= mgs18_nxt;
      sgn18_r <= sgn17_r;
      for (int i = 0; i < 4; i++) sq_r[i] <= mgs18_r[i] * mgs18_r[i];
      mgs19_r <= mgs18_r;
      sgn19_r <= sgn18_r;
      sum_r <= sum_nxt;
      mgs20_r <= mgs19_r;
      sgn20_r <= sgn19_r;
      sv_r <= sv_nxt;
      sr_r <= sr_nxt;
      mq_r[0] <= mgs20_r;
      sg_r[0] <= sgn20_r;
      for (int k = 1; k < 32; k++) begin
        mq_r[k] <= mq_r[k-1];
        sg_r[k] <= sg_r[k-1];
      end
      drem_r <= drem_nxt;
      dlow_r <= dlow_nxt;
      dq_r   <= dq_nxt;
      dn_r[0] <= sr_r[31][31:0];
      dz_r[0] <= (sr_r[31] == 64'd0);
      dsg_r[0] <= sg_r[31];
      for (int k = 1; k < 32; k++) begin
        dn_r[k]  <= dn_r[k-1];
        dz_r[k]  <= dz_r[k-1];
        dsg_r[k] <= dsg_r[k-1];
      end
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_xfer};
    end
  end

  // final sign and the zero-length case
  logic [127:0] res_data;

  always_comb begin
    logic [31:0] qv;
    for (int i = 0; i < 4; i++) begin
      qv = {1'b0, dq_r[31][i]};
      if (dz_r[31]) begin
        res_data[32*i +: 32] = (i == 3) ? OUT_ONE : 32'd0;
      end else if (dsg_r[31][i]) begin
        res_data[32*i +: 32] = -qv;
      end else begin
        res_data[32*i +: 32] = qv;
      end
    end
  end

  // output register with a skid stage behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (out_tready || !out_vld_r) begin
      if (skid_vld_r) begin
        out_vld_r  <= 1'b1;
        out_data_r <= skid_data_r;
        skid_vld_r <= 1'b0;
      end else begin
        out_vld_r  <= en & vld_r[LAT-1];
        out_data_r <= res_data;
      end
    end else if (en && vld_r[LAT-1]) begin
      skid_vld_r  <= 1'b1;
      skid_data_r <= res_data;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  // checks
  `GQRK4_ASSERT_NOW(a_skid_behind_out, clk, rst_n, skid_vld_r, out_vld_r,
    "skid holds a result while the output register is empty")
  `GQRK4_ASSERT_NEXT(a_stall_freezes, clk, rst_n, !en, $stable(vld_r),
    "pipeline valid bits moved during a stall")
  `GQRK4_ASSERT_NOW(a_norm_covers, clk, rst_n, vld_r[51],
    (sr_r[31] >= 64'(mq_r[31][0])) && (sr_r[31] >= 64'(mq_r[31][1])) &&
    (sr_r[31] >= 64'(mq_r[31][2])) && (sr_r[31] >= 64'(mq_r[31][3])),
    "square root below a component magnitude")
  `GQRK4_ASSERT_NOW(a_unit_range, clk, rst_n, out_vld_r,
    ($signed(out_data_r[31:0]) <= $signed(OUT_ONE)) &&
    ($signed(out_data_r[31:0]) >= -$signed(OUT_ONE)) &&
    ($signed(out_data_r[127:96]) <= $signed(OUT_ONE)) &&
    ($signed(out_data_r[127:96]) >= -$signed(OUT_ONE)),
    "normalized component outside unit range")

endmodule

// ===== bench/tb_gyro_quaternion_rk4_increment_unit.sv =====
// testbench for the rk4 gyro quaternion increment unit: directed table plus random
// gyro pairs, every result checked against a bit-accurate fixed-point predictor
// depends on gqrk4_pkg and gyro_quaternion_rk4_increment_unit
`timescale 1ns / 1ps
module tb_gyro_quaternion_rk4_increment_unit;
  import gqrk4_pkg::*;

  localparam int LATENCY = 85;
  localparam int N_RANDOM = 1030;
  localparam logic signed [63:0] LIM = 64'sd140737488355327;
  localparam logic signed [63:0] ONE = 64'sd1073741824;

  typedef struct packed {
    logic [23:0] step_time;
    logic signed [31:0] cz, cy, cx, pz, py, px;
  } gyro_pair_t;

  typedef struct packed {
    logic signed [31:0] w, z, y, x;
  } quat_t;

  typedef struct {
    gyro_pair_t in;
    logic check_fixed;
    quat_t fixed;
  } table_row_t;

  logic clk, rst_n;
  logic in_tvalid, in_tready, out_tvalid, out_tready;
  logic [215:0] in_tdata;
  logic [127:0] out_tdata;

  quat_t expected_quats[$];
  int errors = 0;
  int results_seen = 0;
  bit stim_done = 0;
  bit long_hold = 0;

  gyro_quaternion_rk4_increment_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // fixed-point helpers mirroring the block's arithmetic
  function automatic logic signed [63:0] sat47(input logic signed [63:0] v);
    if (v > LIM) return LIM;
    if (v < -LIM) return -LIM;
    return v;
  endfunction

  function automatic logic signed [63:0] sadd(input logic signed [63:0] a, b);
    return sat47(a + b);
  endfunction

  function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                    input int n);
    logic [63:0] m;
    m = v < 0 ? -v : v;
    m = (m + (64'd1 << (n - 1))) >> n;
    return v < 0 ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [63:0] qmul(input logic signed [63:0] a, b);
    logic [127:0] p;
    logic [127:0] r;
    p = (a < 0 ? -a : a) * (b < 0 ? -b : b);
    r = (p + (128'd1 << 29)) >> 30;
    if (r > LIM) r = LIM;
    return ((a < 0) != (b < 0)) ? -$signed(r[63:0]) : $signed(r[63:0]);
  endfunction

  // omega(rate) applied to a quaternion, order x y z w
  function automatic void omega_apply(input logic signed [63:0] a[3],
                                      input logic signed [63:0] q[4],
                                      output logic signed [63:0] o[4]);
    o[0] = sadd(sadd(qmul(a[2], q[1]), -qmul(a[1], q[2])), qmul(a[0], q[3]));
    o[1] = sadd(sadd(-qmul(a[2], q[0]), qmul(a[0], q[2])), qmul(a[1], q[3]));
    o[2] = sadd(sadd(qmul(a[1], q[0]), -qmul(a[0], q[1])), qmul(a[2], q[3]));
    o[3] = sadd(sadd(-qmul(a[0], q[0]), -qmul(a[1], q[1])), -qmul(a[2], q[2]));
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic quat_t rk4_increment(input gyro_pair_t g);
    logic signed [63:0] ap[3], am[3], ac[3], idq[4], k1[4], k2[4], k3[4], k4[4];
    logic signed [63:0] stage[4], acc[4], t, step;
    logic signed [63:0] wp[3], wc[3];
    logic [63:0] mg[4], mx, sum, nrm, m;
    int sh;
    quat_t q;
    step = {40'd0, g.step_time};
    wp[0] = g.px; wp[1] = g.py; wp[2] = g.pz;
    wc[0] = g.cx; wc[1] = g.cy; wc[2] = g.cz;
    for (int i = 0; i < 3; i++) begin
      ap[i] = rnd_shift(step * wp[i], 11);
      ac[i] = rnd_shift(step * wc[i], 11);
      am[i] = rnd_shift(step * (wp[i] + wc[i]), 12);
    end
    idq[0] = 0; idq[1] = 0; idq[2] = 0; idq[3] = ONE;
    omega_apply(ap, idq, k1);
    for (int i = 0; i < 4; i++) stage[i] = sadd(idq[i], rnd_shift(k1[i], 1));
    omega_apply(am, stage, k2);
    for (int i = 0; i < 4; i++) stage[i] = sadd(idq[i], rnd_shift(k2[i], 1));
    omega_apply(am, stage, k3);
    for (int i = 0; i < 4; i++) stage[i] = sadd(idq[i], k3[i]);
    omega_apply(ac, stage, k4);
    mx = 0;
    for (int i = 0; i < 4; i++) begin
      t = k1[i];
      t = sadd(t, sadd(k2[i], k2[i]));
      t = sadd(t, sadd(k3[i], k3[i]));
      t = sadd(t, k4[i]);
      m = t < 0 ? -t : t;
      m = (m + 3) / 6;
      acc[i] = sadd(idq[i], t < 0 ? -$signed(m) : $signed(m));
      mg[i] = acc[i] < 0 ? -acc[i] : acc[i];
      if (mg[i] > mx) mx = mg[i];
    end
    sh = 0;
    while (mx > 64'h7FFF_FFFF) begin
      mx >>= 1;
      sh++;
    end
    sum = 0;
    for (int i = 0; i < 4; i++) begin
      mg[i] >>= sh;
      sum += mg[i] * mg[i];
    end
    nrm = int_sqrt(sum);
    for (int i = 0; i < 4; i++) begin
      logic signed [31:0] r;
      if (nrm == 0) begin
        r = (i == 3) ? 32'sd1073741824 : 32'sd0;
      end else begin
        m = ((mg[i] << 30) + nrm / 2) / nrm;
        r = acc[i] < 0 ? -$signed(m[31:0]) : $signed(m[31:0]);
      end
      q[32*i +: 32] = r;
    end
    return q;
  endfunction

  function automatic gyro_pair_t random_pair();
    gyro_pair_t g;
    int kind;
    kind = $urandom_range(0, 9);
    g = 216'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    if (kind < 6) begin
      // realistic rates up to a few rad/s and short steps
      g.px = $signed(32'($urandom_range(0, 1 << 20))) - (1 << 19);
      g.py = $signed(32'($urandom_range(0, 1 << 20))) - (1 << 19);
      g.pz = $signed(32'($urandom_range(0, 1 << 20))) - (1 << 19);
      g.cx = g.px + $signed(32'($urandom_range(0, 1 << 16))) - (1 << 15);
      g.cy = g.py + $signed(32'($urandom_range(0, 1 << 16))) - (1 << 15);
      g.cz = g.pz + $signed(32'($urandom_range(0, 1 << 16))) - (1 << 15);
      g.step_time = 24'($urandom_range(0, 1 << 18));
    end else if (kind < 8) begin
      g.step_time = 24'($urandom_range(0, 24'hFFFFFF) >> $urandom_range(0, 23));
    end
    return g;
  endfunction

  // drive one transfer after a random gap
  task automatic send_pair(input gyro_pair_t g);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      in_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= g;
    expected_quats.push_back(rk4_increment(g));
    do @(posedge clk); while (!in_tready);
  endtask

  // stimulus
  initial begin
    table_row_t rows[$];
    table_row_t r;
    gyro_pair_t g;
    in_tvalid = 0;
    in_tdata = '0;
    rst_n = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // a zero step or zero rates give the identity
    r.check_fixed = 1;
    r.fixed = {32'sd1073741824, 32'sd0, 32'sd0, 32'sd0};
    r.in = '0; rows.push_back(r);
    r.in = '0; r.in.px = 32'h7FFF_FFFF; r.in.cz = 32'h8000_0000; rows.push_back(r);
    r.in = '0; r.in.step_time = 24'hFF_FFFF; rows.push_back(r);
    r.check_fixed = 0;
    // extremes of every field, including saturating rotations
    r.in = {24'hFF_FFFF, {6{32'h7FFF_FFFF}}}; rows.push_back(r);
    r.in = {24'hFF_FFFF, {6{32'h8000_0000}}}; rows.push_back(r);
    r.in = {24'hFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
            32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF}; rows.push_back(r);
    r.in = {24'h00_0001, {6{32'hFFFF_FFFF}}}; rows.push_back(r);
    r.in = {24'h00_0001, {6{32'h0000_0001}}}; rows.push_back(r);
    // single axis rotations
    r.in = '0; r.in.step_time = 24'h01_0000; r.in.px = 32'h0001_0000;
    r.in.cx = 32'h0001_0000; rows.push_back(r);
    r.in = '0; r.in.step_time = 24'h10_0000; r.in.py = 32'hFFFE_0000;
    r.in.cy = 32'hFFFD_0000; rows.push_back(r);
    r.in = '0; r.in.step_time = 24'h80_0000; r.in.pz = 32'h0003_2440;
    r.in.cz = 32'h0003_2440; rows.push_back(r);
    // pi rotation, scalar part near zero
    r.in = '0; r.in.step_time = 24'hFF_FFFF; r.in.px = 32'h0003_2440;
    r.in.cx = 32'h0003_2440; rows.push_back(r);
    r.in = {24'h00_4000, 32'h0000_8000, 32'hFFFF_0000, 32'h0002_0000,
            32'h0000_4000, 32'hFFFE_8000, 32'h0001_0000}; rows.push_back(r);

    foreach (rows[i]) begin
      send_pair(rows[i].in);
      if (rows[i].check_fixed && expected_quats[$] != rows[i].fixed) begin
        $display("%0t predictor disagrees on table row %0d: expected %h got %h",
                 $time, i, rows[i].fixed, expected_quats[$]);
        errors++;
      end
    end

    // back-to-back burst while the receiver holds off, filling the pipeline
    long_hold = 1;
    repeat (150) begin
      g = random_pair();
      in_tvalid <= 1;
      in_tdata <= g;
      expected_quats.push_back(rk4_increment(g));
      do @(posedge clk); while (!in_tready);
    end
    long_hold = 0;

    for (int n = 0; n < N_RANDOM - 150; n++) send_pair(random_pair());
    in_tvalid <= 0;
    stim_done = 1;
  end

  // receiver stalls, with one long hold-off during the burst
  initial begin
    int gap;
    bit held;
    held = 0;
    out_tready = 0;
    @(posedge rst_n);
    forever begin
      if (long_hold && !held) begin
        out_tready <= 0;
        repeat (300) @(posedge clk);
        held = 1;
      end
      gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 11);
      if (gap != 0) begin
        out_tready <= 0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1;
      @(posedge clk);
    end
  end

  // compare every result transfer with the oldest prediction
  always @(posedge clk) begin
    quat_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      results_seen++;
      if (expected_quats.size() == 0) begin
        $display("%0t unexpected result transfer %h", $time, got);
        errors++;
      end else begin
        want = expected_quats.pop_front();
        if (got.x !== want.x) begin
          $display("%0t quat_x expected %0d actual %0d", $time, want.x, got.x);
          errors++;
        end
        if (got.y !== want.y) begin
          $display("%0t quat_y expected %0d actual %0d", $time, want.y, got.y);
          errors++;
        end
        if (got.z !== want.z) begin
          $display("%0t quat_z expected %0d actual %0d", $time, want.z, got.z);
          errors++;
        end
        if (got.w !== want.w) begin
          $display("%0t quat_w expected %0d actual %0d", $time, want.w, got.w);
          errors++;
        end
      end
    end
  end

  // end of run
  initial begin
    wait (stim_done);
    while (expected_quats.size() != 0) @(posedge clk);
    repeat (2 * LATENCY) @(posedge clk);
    $display("run covered %0d quaternion increments: directed extremes, saturating", results_seen);
    $display("rotations, a stalled back-to-back burst and random gyro pairs");
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
